// ===== design/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants of the serpentine error-diffusion ditherer:
// default sizes, configuration reset value and the palette reconstruction
// tables.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int ERROR_BITS_DEF = 16;

	localparam int PIX_W = 8;
	localparam int CFG_W = 11;
	localparam int COL_W = 10;
	localparam int LVL_W = 3;

	localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 11'd1024;

	// Highest level of the red and green channels and of the blue channel.
	localparam logic [LVL_W-1:0] RG_TOP_LVL = 3'd7;
	localparam logic [LVL_W-1:0] B_TOP_LVL  = 3'd3;

	// Reconstructed component for each level: level*255/7 and level*255/3.
	localparam logic [PIX_W-1:0] RECON_RG [8] = '{
		8'd0, 8'd36, 8'd72, 8'd109, 8'd145, 8'd182, 8'd218, 8'd255
	};
	localparam logic [PIX_W-1:0] RECON_B [4] = '{8'd0, 8'd85, 8'd170, 8'd255};

endpackage

// ===== design/sfd_pix_if.sv =====
// ----------------------------------------------------------------------------
// sfd_pix_if
// Pixel channel: one 24-bit RGB pixel per item with its line flags.
// ----------------------------------------------------------------------------
interface sfd_pix_if;
	import sfd_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;
	logic             odd_line;
	logic             first_line;

	modport source (output valid, red, green, blue, odd_line, first_line, input ready);
	modport sink   (input valid, red, green, blue, odd_line, first_line, output ready);

endinterface

// ===== design/sfd_res_if.sv =====
// ----------------------------------------------------------------------------
// sfd_res_if
// Result channel: one palette index and its image column per item.
// ----------------------------------------------------------------------------
interface sfd_res_if;
	import sfd_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] palette_index;
	logic [COL_W-1:0] column;

	modport source (output valid, palette_index, column, input ready);
	modport sink   (input valid, palette_index, column, output ready);

endinterface

// ===== design/sfd_row_ram.sv =====
// ----------------------------------------------------------------------------
// sfd_row_ram
// Simple dual-port row store: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module sfd_row_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/sfd_chan_calc.sv =====
// ----------------------------------------------------------------------------
// sfd_chan_calc
// One color channel of the ditherer: adds the owed error, quantizes,
// and computes the diffused error terms for the row store and the carry.
// ----------------------------------------------------------------------------
module sfd_chan_calc #(
	parameter int ERROR_BITS = 16
) (
	input  logic [sfd_pkg::PIX_W-1:0]   pixel,
	input  logic                        blue_mode,
	input  logic signed [ERROR_BITS-1:0] stored,
	input  logic signed [ERROR_BITS-1:0] ahead,
	input  logic signed [ERROR_BITS-1:0] bp0,
	input  logic signed [ERROR_BITS-1:0] bp1,
	output logic [sfd_pkg::LVL_W-1:0]   level,
	output logic signed [ERROR_BITS-1:0] below_prev,
	output logic signed [ERROR_BITS-1:0] below_new,
	output logic signed [ERROR_BITS-1:0] c_sat,
	output logic signed [ERROR_BITS-1:0] ahead_new
);
	import sfd_pkg::*;

	localparam int SW = ERROR_BITS + 8;
	localparam logic signed [SW-1:0] E_MAX    = SW'((2 ** (ERROR_BITS - 1)) - 1);
	localparam logic signed [SW-1:0] E_MIN    = SW'(-(2 ** (ERROR_BITS - 1)));
	localparam logic signed [SW-1:0] RND_BIAS = SW'(8);

	function automatic logic signed [ERROR_BITS-1:0] sat_e(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		if (v > E_MAX) begin
			r = E_MAX;
		end else if (v < E_MIN) begin
			r = E_MIN;
		end else begin
			r = v;
		end
		return ERROR_BITS'(r);
	endfunction

	logic signed [SW-1:0]     e_sum, e_x, rnd, px_x, t, q, act_x, c;
	logic signed [ERROR_BITS-1:0] e;
	logic [LVL_W-1:0]         top;
	logic [PIX_W-1:0]         act;

	always_comb begin
		e_sum = SW'(stored) + SW'(ahead);
		e     = sat_e(e_sum);
		e_x   = SW'(e);
		// Arithmetic shift gives the floor of (e + 8) / 16.
		rnd   = (e_x + RND_BIAS) >>> 4;
		px_x  = SW'(pixel);
		t     = px_x + rnd;

		q   = blue_mode ? (t >>> 6) : (t >>> 5);
		top = blue_mode ? B_TOP_LVL : RG_TOP_LVL;
		if (t < 0) begin
			level = '0;
		end else if (q >= $signed(SW'(top))) begin
			level = top;
		end else begin
			level = LVL_W'(q);
		end
		act   = blue_mode ? RECON_B[level[1:0]] : RECON_RG[level];
		act_x = SW'(act);
		c     = t - act_x;

		below_prev = sat_e(SW'(bp0) + (c <<< 1) + c);
		below_new  = sat_e(SW'(bp1) + (c <<< 2) + c);
		c_sat      = sat_e(c);
		ahead_new  = sat_e((c <<< 3) - c);
	end

endmodule

// ===== design/serpentine_fs_dither_rgb332.sv =====
// ----------------------------------------------------------------------------
// serpentine_fs_dither_rgb332
// Serpentine Floyd-Steinberg ditherer from 24-bit RGB to a 3-3-2 palette,
// with its error rows kept in two ping-pong row memories.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on pix in serpentine order (left to right on even lines, right
// to left on odd lines) with odd_line and first_line flags. Each item yields
// one item on res: the palette index and the pixel's column from the left.
// cfg_we/cfg_wdata set the line width; write it only while the block is idle.
// An accepted item passes through the stage one register and the output register.
// Throughput: one item per cycle while res takes results. That rate is set by
// the per-pixel error loop in stage one, where the ahead carry of a pixel feeds
// the next one, and by the single write port of each row memory. The last
// pixel of a multi-pixel line writes two row entries; the second one is held
// and written while its memory takes no new write, as when the first pixel of
// the next line writes nothing. Reads of entries still in flight are forwarded.
// Reset: the line width becomes 1024 and the column counter zero. The row
// memories are not cleared; the first line of an image reads them as zero.
// Stall: a result the receiver does not take stays in the output register;
// an item in stage one then holds, and pix.ready falls, until the result is taken.
// ----------------------------------------------------------------------------
module serpentine_fs_dither_rgb332 #(
	parameter int MAX_WIDTH  = sfd_pkg::MAX_WIDTH_DEF,
	parameter int ERROR_BITS = sfd_pkg::ERROR_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [sfd_pkg::CFG_W-1:0] cfg_wdata,
	sfd_pix_if.sink                   pix,
	sfd_res_if.source                 res
);
	import sfd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EB = ERROR_BITS;
	localparam int EW = 3 * ERROR_BITS;

	// Configuration and column counter.
	logic [CFG_W-1:0] line_width_q;
	logic [CW-1:0]    cnt_q;
	logic [WW-1:0]    w_eff, w_m1;
	logic [CW-1:0]    p0, col0, prev0;
	logic             last0, pz0;

	// Pipeline control.
	logic s1_vld_q, res_vld_q, res_free, s1_fire, in_fire;

	// Stage one payload.
	logic [PIX_W-1:0] red_s1, green_s1, blue_s1;
	logic             odd_s1, first_s1, pz_s1, last_s1;
	logic [CW-1:0]    col_s1, prev_s1;
	logic             fwd_vld_s1;
	logic [EW-1:0]    fwd_data_s1;

	// Row memories.
	logic [EW-1:0] even_rd, odd_rd, rd_sel, stored_vec;
	logic          even_we, odd_we;
	logic [CW-1:0] even_waddr, odd_waddr;
	logic [EW-1:0] even_wdata, odd_wdata;

	// Row writes from stage one and the held second write.
	logic          wr_mem_s1, wa_vld, wb_vld, d_vld, d_mem;
	logic [CW-1:0] d_addr;
	logic [EW-1:0] wa_data, wb_data, d_data;
	logic          pend_vld_q, pend_mem_q, pend_go;
	logic [CW-1:0] pend_addr_q;
	logic [EW-1:0] pend_data_q;

	// Forwarding into the read of the accepted pixel.
	logic          hit_a, hit_b, hit_p;

	// Per-channel error state and results.
	logic signed [EB-1:0] ahead_q [3];
	logic signed [EB-1:0] bp0_q [3];
	logic signed [EB-1:0] bp1_q [3];
	logic signed [EB-1:0] ahead_in [3], bp0_in [3], bp1_in [3], stored_ch [3];
	logic signed [EB-1:0] below_prev [3], below_new [3], c_sat [3], ahead_new [3];
	logic [LVL_W-1:0]     lvl [3];
	logic [PIX_W-1:0]     px_ch [3];

	// Output register.
	logic [PIX_W-1:0] pal_q;
	logic [COL_W-1:0] col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
		end else if (cfg_we) begin
			line_width_q <= cfg_wdata;
		end
	end

	// Column position of the accepted pixel.
	always_comb begin
		if (line_width_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(line_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(line_width_q);
		end
		w_m1 = w_eff - WW'(1);
		// A counter left past a lowered width makes the pixel the last one.
		if (WW'(cnt_q) >= w_eff) begin
			p0 = CW'(w_m1);
		end else begin
			p0 = cnt_q;
		end
		last0 = (WW'(p0) == w_m1);
		pz0   = (p0 == '0);
		col0  = pix.odd_line ? CW'(w_m1 - WW'(p0)) : p0;
		prev0 = pix.odd_line ? CW'(w_eff - WW'(p0)) : p0 - CW'(1);
	end

	assign res_free  = !res_vld_q || res.ready;
	assign s1_fire   = s1_vld_q && res_free;
	assign pix.ready = !s1_vld_q || res_free;
	assign in_fire   = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			s1_vld_q  <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (in_fire) begin
				cnt_q <= last0 ? '0 : p0 + CW'(1);
			end
			if (in_fire) begin
				s1_vld_q <= 1'b1;
			end else if (s1_fire) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_fire) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// Writes produced by the pixel leaving stage one. Its row is the other
	// memory than the one it read.
	always_comb begin
		wr_mem_s1 = !odd_s1;
		wa_vld    = s1_fire && !pz_s1;
		wb_vld    = s1_fire && last_s1;
		d_vld     = wa_vld || wb_vld;
		d_mem     = wr_mem_s1;
		d_addr    = wa_vld ? prev_s1 : col_s1;
		d_data    = wa_vld ? wa_data : wb_data;
		pend_go   = pend_vld_q && !(d_vld && (d_mem == pend_mem_q));

		even_we    = 1'b0;
		even_waddr = pend_addr_q;
		even_wdata = pend_data_q;
		odd_we     = 1'b0;
		odd_waddr  = pend_addr_q;
		odd_wdata  = pend_data_q;
		if (d_vld && !d_mem) begin
			even_we    = 1'b1;
			even_waddr = d_addr;
			even_wdata = d_data;
		end else if (pend_go && !pend_mem_q) begin
			even_we = 1'b1;
		end
		if (d_vld && d_mem) begin
			odd_we    = 1'b1;
			odd_waddr = d_addr;
			odd_wdata = d_data;
		end else if (pend_go && pend_mem_q) begin
			odd_we = 1'b1;
		end

		hit_a = wa_vld && (wr_mem_s1 == pix.odd_line) && (prev_s1 == col0);
		hit_b = wb_vld && (wr_mem_s1 == pix.odd_line) && (col_s1 == col0);
		hit_p = pend_vld_q && (pend_mem_q == pix.odd_line) && (pend_addr_q == col0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (wa_vld && wb_vld) begin
			pend_vld_q <= 1'b1;
		end else if (pend_go) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wa_vld && wb_vld) begin
			pend_mem_q  <= wr_mem_s1;
			pend_addr_q <= col_s1;
			pend_data_q <= wb_data;
		end
	end

	// Stage one payload, including the forwarded row entry when the read
	// address is still being written.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			red_s1      <= pix.red;
			green_s1    <= pix.green;
			blue_s1     <= pix.blue;
			odd_s1      <= pix.odd_line;
			first_s1    <= pix.first_line;
			pz_s1       <= pz0;
			last_s1     <= last0;
			col_s1      <= col0;
			prev_s1     <= prev0;
			fwd_vld_s1  <= hit_a || hit_b || hit_p;
			fwd_data_s1 <= hit_a ? wa_data : (hit_b ? wb_data : pend_data_q);
		end
	end

	sfd_row_ram #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (EW)
	) u_even_ram (
		.clk   (clk),
		.we    (even_we),
		.waddr (even_waddr),
		.wdata (even_wdata),
		.re    (in_fire),
		.raddr (col0),
		.rdata (even_rd)
	);

	sfd_row_ram #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (EW)
	) u_odd_ram (
		.clk   (clk),
		.we    (odd_we),
		.waddr (odd_waddr),
		.wdata (odd_wdata),
		.re    (in_fire),
		.raddr (col0),
		.rdata (odd_rd)
	);

	always_comb begin
		rd_sel = odd_s1 ? odd_rd : even_rd;
		if (first_s1) begin
			stored_vec = '0;
		end else if (fwd_vld_s1) begin
			stored_vec = fwd_data_s1;
		end else begin
			stored_vec = rd_sel;
		end
	end

	assign px_ch[0] = red_s1;
	assign px_ch[1] = green_s1;
	assign px_ch[2] = blue_s1;

	for (genvar g = 0; g < 3; g++) begin : g_chan
		// The line's first pixel starts with no carry and no partials.
		assign stored_ch[g] = stored_vec[g*EB +: EB];
		assign ahead_in[g]  = pz_s1 ? '0 : ahead_q[g];
		assign bp0_in[g]    = pz_s1 ? '0 : bp0_q[g];
		assign bp1_in[g]    = pz_s1 ? '0 : bp1_q[g];

		sfd_chan_calc #(
			.ERROR_BITS (ERROR_BITS)
		) u_calc (
			.pixel      (px_ch[g]),
			.blue_mode  (g == 2),
			.stored     (stored_ch[g]),
			.ahead      (ahead_in[g]),
			.bp0        (bp0_in[g]),
			.bp1        (bp1_in[g]),
			.level      (lvl[g]),
			.below_prev (below_prev[g]),
			.below_new  (below_new[g]),
			.c_sat      (c_sat[g]),
			.ahead_new  (ahead_new[g])
		);

		assign wa_data[g*EB +: EB] = below_prev[g];
		assign wb_data[g*EB +: EB] = below_new[g];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ahead_q[g] <= '0;
				bp0_q[g]   <= '0;
				bp1_q[g]   <= '0;
			end else if (s1_fire) begin
				ahead_q[g] <= ahead_new[g];
				bp0_q[g]   <= below_new[g];
				bp1_q[g]   <= c_sat[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			pal_q <= {lvl[0], lvl[1], lvl[2][1:0]};
			col_q <= COL_W'(col_s1);
		end
	end

	assign res.valid         = res_vld_q;
	assign res.palette_index = pal_q;
	assign res.column        = col_q;

	// The held second write must never compete with a new write to its memory.
	a_pend_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_vld_q && d_vld && (d_mem == pend_mem_q)))
		else $error("held row write collides with a new write");

	// The held write drains in the cycle after the last pixel of a line.
	a_pend_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |=> !pend_vld_q)
		else $error("held row write stayed for more than one cycle");

	// A line's first pixel of a multi-pixel line never writes a row entry.
	a_first_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && pz_s1 && !last_s1) |-> !d_vld)
		else $error("row write from the first pixel of a line");

endmodule
